FILE: rtl/core/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared types, codes and sizes of the index free list allocator.
// ----------------------------------------------------------------------------
package ifla_pkg;

  localparam int HEAP_SIZE = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int TOT_W     = 12;

  localparam logic [CNT_W-1:0] HEAP_CNT = CNT_W'(HEAP_SIZE);

  // request codes
  localparam logic [1:0] ACT_ALLOC_ONE = 2'd0;
  localparam logic [1:0] ACT_ALLOC_RUN = 2'd1;
  localparam logic [1:0] ACT_FREE_ONE  = 2'd2;
  localparam logic [1:0] ACT_FREE_RUN  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] run_length;
    logic             handle_valid;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] allocated_count;
    logic [TOT_W-1:0] free_total;
    logic [CNT_W-1:0] high_watermark;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_POP_RD, OP_POP_DONE, OP_BUMP1, OP_NOSPACE, OP_IGNORE,
    OP_PUSH1, OP_PUSH_INIT, OP_PUSH_RUN, OP_OVERFLOW, OP_SORT_INIT, OP_SORT_RDV,
    OP_SORT_LATV, OP_SORT_RDJ, OP_SORT_SHIFT, OP_SORT_PLACE, OP_SCAN_INIT,
    OP_SCAN_RD, OP_SCAN_CHK, OP_MOVE_INIT, OP_MOVE_RD, OP_MOVE_WR, OP_MOVE_END,
    OP_TRYBUMP, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic [1:0] action;
    logic       n_zero;
    logic       hv;
    logic       fc_zero;
    logic       fc_ge_n;
    logic       bump1_ok;
    logic       i_eq_n;
    logic       fc_full;
    logic       i_ge_fc;
    logic       j_zero;
    logic       rd_gt_v;
    logic       len_eq_n;
    logic       p_ge_fc;
    logic       mv_done;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/ifla_ram.sv
// ----------------------------------------------------------------------------
// ifla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ifla_ctrl.sv
// ----------------------------------------------------------------------------
// ifla_ctrl
// Sequencer: steps the datapath through pop, push, sort, scan and compaction.
// ----------------------------------------------------------------------------
module ifla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifla_pkg::dp_stat_t stat,
  output ifla_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_POP_WAIT, S_PUSH_LOOP, S_SORT_OUTER, S_SORT_GETV,
    S_SORT_INNER, S_SORT_CMP, S_SCAN_RD, S_SCAN_CHK, S_MOVE_RD, S_MOVE_WR,
    S_TRYBUMP, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = ifla_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ifla_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (stat.action)
          ifla_pkg::ACT_ALLOC_ONE: begin
            if (!stat.fc_zero) begin
              cmd.op     = ifla_pkg::OP_POP_RD;
              state_next = S_POP_WAIT;
            end else if (stat.bump1_ok) begin
              cmd.op = ifla_pkg::OP_BUMP1;
            end else begin
              cmd.op = ifla_pkg::OP_NOSPACE;
            end
          end
          ifla_pkg::ACT_ALLOC_RUN: begin
            if (stat.n_zero) begin
              cmd.op = ifla_pkg::OP_IGNORE;
            end else if (stat.fc_ge_n) begin
              cmd.op     = ifla_pkg::OP_SORT_INIT;
              state_next = S_SORT_OUTER;
            end else begin
              state_next = S_TRYBUMP;
            end
          end
          ifla_pkg::ACT_FREE_ONE: begin
            cmd.op = stat.hv ? ifla_pkg::OP_PUSH1 : ifla_pkg::OP_IGNORE;
          end
          default: begin
            if (!stat.hv || stat.n_zero) begin
              cmd.op = ifla_pkg::OP_IGNORE;
            end else begin
              cmd.op     = ifla_pkg::OP_PUSH_INIT;
              state_next = S_PUSH_LOOP;
            end
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.op     = ifla_pkg::OP_POP_DONE;
        state_next = S_FINISH;
      end
      S_PUSH_LOOP: begin
        if (stat.i_eq_n) begin
          state_next = S_FINISH;
        end else if (stat.fc_full) begin
          cmd.op     = ifla_pkg::OP_OVERFLOW;
          state_next = S_FINISH;
        end else begin
          cmd.op = ifla_pkg::OP_PUSH_RUN;
        end
      end
      S_SORT_OUTER: begin
        if (stat.i_ge_fc) begin
          cmd.op     = ifla_pkg::OP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end else begin
          cmd.op     = ifla_pkg::OP_SORT_RDV;
          state_next = S_SORT_GETV;
        end
      end
      S_SORT_GETV: begin
        cmd.op     = ifla_pkg::OP_SORT_LATV;
        state_next = S_SORT_INNER;
      end
      S_SORT_INNER: begin
        if (stat.j_zero) begin
          cmd.op     = ifla_pkg::OP_SORT_PLACE;
          state_next = S_SORT_OUTER;
        end else begin
          cmd.op     = ifla_pkg::OP_SORT_RDJ;
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat.rd_gt_v) begin
          cmd.op     = ifla_pkg::OP_SORT_SHIFT;
          state_next = S_SORT_INNER;
        end else begin
          cmd.op     = ifla_pkg::OP_SORT_PLACE;
          state_next = S_SORT_OUTER;
        end
      end
      S_SCAN_RD: begin
        if (stat.len_eq_n) begin
          cmd.op     = ifla_pkg::OP_MOVE_INIT;
          state_next = S_MOVE_RD;
        end else if (stat.p_ge_fc) begin
          state_next = S_TRYBUMP;
        end else begin
          cmd.op     = ifla_pkg::OP_SCAN_RD;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.op     = ifla_pkg::OP_SCAN_CHK;
        state_next = S_SCAN_RD;
      end
      S_MOVE_RD: begin
        if (stat.mv_done) begin
          cmd.op     = ifla_pkg::OP_MOVE_END;
          state_next = S_FINISH;
        end else begin
          cmd.op     = ifla_pkg::OP_MOVE_RD;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.op     = ifla_pkg::OP_MOVE_WR;
        state_next = S_MOVE_RD;
      end
      S_TRYBUMP: begin
        cmd.op     = ifla_pkg::OP_TRYBUMP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op     = ifla_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted transaction not dispatched");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ifla_pkg::OP_EMIT) |=> (state == S_IDLE))
    else $error("controller did not return to idle after result");
  a_no_stall_in_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !stat.out_free) |=> (state == S_FINISH))
    else $error("result lost while output busy");
`endif

endmodule

FILE: rtl/core/ifla_dp.sv
// ----------------------------------------------------------------------------
// ifla_dp
// Datapath: free list memory, counters, request and result registers.
// ----------------------------------------------------------------------------
module ifla_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ifla_pkg::in_item_t                 in_data,
  input  logic                               cfg_valid,
  input  logic [ifla_pkg::CNT_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ifla_pkg::out_item_t                out_data,
  input  ifla_pkg::dp_cmd_t                  cmd,
  output ifla_pkg::dp_stat_t                 stat
);

  localparam int IW = ifla_pkg::IDX_W;
  localparam int CW = ifla_pkg::CNT_W;
  localparam int TW = ifla_pkg::TOT_W;

  logic [CW-1:0] capacity, free_count, next_offset;
  ifla_pkg::in_item_t req;
  logic [CW-1:0] cnt, j, p, len;
  logic [IW-1:0] v, s, prev, base, start;
  logic [1:0]    status;

  logic          we, re;
  logic [IW-1:0] waddr, raddr, wdata, rdata;

  logic [CW-1:0] cap;
  logic [TW-1:0] mv_src, bump_end;
  logic [CW-1:0] alloc_cnt;
  logic [TW-1:0] free_tot;

  assign cap      = (capacity > ifla_pkg::HEAP_CNT) ? ifla_pkg::HEAP_CNT : capacity;
  assign mv_src   = TW'(cnt) + TW'(req.run_length);
  assign bump_end = TW'(next_offset) + TW'(req.run_length);

  assign alloc_cnt = (next_offset >= free_count) ? (next_offset - free_count) : '0;
  assign free_tot  = (cap >= next_offset) ? (TW'(cap) - TW'(next_offset) + TW'(free_count))
                                          : TW'(free_count);

  ifla_ram #(.WIDTH(IW), .DEPTH(ifla_pkg::HEAP_SIZE)) u_list (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // memory port steering
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = free_count[IW-1:0];
    wdata = req.index;
    raddr = cnt[IW-1:0];
    case (cmd.op)
      ifla_pkg::OP_POP_RD: begin
        re    = 1'b1;
        raddr = IW'(free_count - CW'(1));
      end
      ifla_pkg::OP_PUSH1:    we = (free_count != ifla_pkg::HEAP_CNT);
      ifla_pkg::OP_PUSH_RUN: begin
        we    = 1'b1;
        wdata = req.index + cnt[IW-1:0];
      end
      ifla_pkg::OP_SORT_RDV: re = 1'b1;
      ifla_pkg::OP_SORT_RDJ: begin
        re    = 1'b1;
        raddr = IW'(j - CW'(1));
      end
      ifla_pkg::OP_SORT_SHIFT: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rdata;
      end
      ifla_pkg::OP_SORT_PLACE: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = v;
      end
      ifla_pkg::OP_SCAN_RD: begin
        re    = 1'b1;
        raddr = p[IW-1:0];
      end
      ifla_pkg::OP_MOVE_RD: begin
        re    = 1'b1;
        raddr = mv_src[IW-1:0];
      end
      ifla_pkg::OP_MOVE_WR: begin
        we    = 1'b1;
        waddr = cnt[IW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= ifla_pkg::HEAP_CNT;
      free_count  <= '0;
      next_offset <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (out_valid && out_ready && cmd.op != ifla_pkg::OP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        ifla_pkg::OP_LOAD: begin
          req    <= in_data;
          status <= ifla_pkg::ST_OK;
          start  <= '0;
        end
        ifla_pkg::OP_POP_RD:   free_count <= free_count - CW'(1);
        ifla_pkg::OP_POP_DONE: start <= rdata;
        ifla_pkg::OP_BUMP1: begin
          start       <= next_offset[IW-1:0];
          next_offset <= next_offset + CW'(1);
        end
        ifla_pkg::OP_NOSPACE:  status <= ifla_pkg::ST_NOSPACE;
        ifla_pkg::OP_IGNORE:   status <= ifla_pkg::ST_IGNORED;
        ifla_pkg::OP_OVERFLOW: status <= ifla_pkg::ST_OVERFLOW;
        ifla_pkg::OP_PUSH1: begin
          if (free_count == ifla_pkg::HEAP_CNT) begin
            status <= ifla_pkg::ST_OVERFLOW;
          end else begin
            free_count <= free_count + CW'(1);
          end
        end
        ifla_pkg::OP_PUSH_INIT: cnt <= '0;
        ifla_pkg::OP_PUSH_RUN: begin
          free_count <= free_count + CW'(1);
          cnt        <= cnt + CW'(1);
        end
        ifla_pkg::OP_SORT_INIT:  cnt <= CW'(1);
        ifla_pkg::OP_SORT_RDV:   j <= cnt;
        ifla_pkg::OP_SORT_LATV:  v <= rdata;
        ifla_pkg::OP_SORT_SHIFT: j <= j - CW'(1);
        ifla_pkg::OP_SORT_PLACE: cnt <= cnt + CW'(1);
        ifla_pkg::OP_SCAN_INIT: begin
          p   <= '0;
          len <= '0;
        end
        ifla_pkg::OP_SCAN_CHK: begin
          // a break in the sequence restarts the candidate run here
          if (len != '0 && CW'(rdata) == CW'(prev) + CW'(1)) begin
            len <= len + CW'(1);
          end else begin
            s    <= p[IW-1:0];
            len  <= CW'(1);
            base <= rdata;
          end
          prev <= rdata;
          p    <= p + CW'(1);
        end
        ifla_pkg::OP_MOVE_INIT: begin
          start <= base;
          cnt   <= CW'(s);
        end
        ifla_pkg::OP_MOVE_WR:  cnt <= cnt + CW'(1);
        ifla_pkg::OP_MOVE_END: free_count <= free_count - req.run_length;
        ifla_pkg::OP_TRYBUMP: begin
          if (bump_end > TW'(cap)) begin
            status <= ifla_pkg::ST_NOSPACE;
          end else begin
            start       <= next_offset[IW-1:0];
            next_offset <= bump_end[CW-1:0];
          end
        end
        ifla_pkg::OP_EMIT: begin
          out_valid                <= 1'b1;
          out_data.start_index     <= (status == ifla_pkg::ST_OK) ? start : '0;
          out_data.status          <= status;
          out_data.allocated_count <= alloc_cnt;
          out_data.free_total      <= free_tot;
          out_data.high_watermark  <= next_offset;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.action   = req.action;
    stat.n_zero   = (req.run_length == '0);
    stat.hv       = req.handle_valid;
    stat.fc_zero  = (free_count == '0);
    stat.fc_ge_n  = (free_count >= req.run_length);
    stat.bump1_ok = (next_offset < cap);
    stat.i_eq_n   = (cnt == req.run_length);
    stat.fc_full  = (free_count == ifla_pkg::HEAP_CNT);
    stat.i_ge_fc  = (cnt >= free_count);
    stat.j_zero   = (j == '0);
    stat.rd_gt_v  = (rdata > v);
    stat.len_eq_n = (len == req.run_length);
    stat.p_ge_fc  = (p >= free_count);
    stat.mv_done  = (mv_src >= TW'(free_count));
    stat.out_free = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= ifla_pkg::HEAP_CNT)
    else $error("free list count beyond heap size");
  a_off_bound: assert property (@(posedge clk) disable iff (rst)
    next_offset <= ifla_pkg::HEAP_CNT)
    else $error("bump offset beyond heap size");
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ifla_pkg::ST_OK) |-> (out_data.start_index == '0))
    else $error("non-zero start index on failed request");
`endif

endmodule

FILE: rtl/core/index_free_list_allocator.sv
// ----------------------------------------------------------------------------
// index_free_list_allocator
// Slot index allocator: a stack-ordered free list backed by a bump offset.
// ----------------------------------------------------------------------------
// one request is worked at a time. allocate one, free one and ignored requests
// go from acceptance through dispatch (a pop from the list also waits for its
// read data) to the result. a run free makes one free list write per slot. a
// run allocation that goes to the list sorts it in place by insertion sort
// through the single read port of the free list memory, reading each entry and
// shifting the larger ones up, then does a linear scan of the entries and a
// compaction of the entries behind the run. the result sits in an output
// register, so a finished transaction never holds back the request side beyond
// the next acceptance. capacity writes are always taken and saturate at the
// heap size; write it only while no request is in flight. the free list memory
// needs no clearing after reset: only entries below the fill count are read
module index_free_list_allocator (
  input  logic                       clk,
  input  logic                       rst,
  // request transaction
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ifla_pkg::in_item_t         in_data,
  // result transaction
  output logic                       out_valid,
  input  logic                       out_ready,
  output ifla_pkg::out_item_t        out_data,
  // capacity register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ifla_pkg::CNT_W-1:0] cfg_data
);

  ifla_pkg::dp_cmd_t  cmd;
  ifla_pkg::dp_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  ifla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // free list storage and counters
  ifla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
